// ----- hdl/mbq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbq_pkg: shared types and constants of the multichannel biquad high-pass
// Field widths, fixed-point constants, register indexes and the records
// that travel between the filter's modules.
// ----------------------------------------------------------------------------
package mbq_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CHANNEL_W   = 6;
  localparam int Y_W         = 32;  // output history, signed Q2.30
  localparam int CFG_INDEX_W = 3;

  // Raw samples are widened to Q.30 by this shift, and 32767 is 2^15 - 1.
  localparam int GAIN_SHIFT = 15;
  localparam int Q30_SHIFT  = 30;
  localparam longint ONE_Q30 = 64'sd1073741824;

  // Coefficient register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FF0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FF1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FF2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FB1 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FB2 = 3'd4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [Y_W-1:0]      y_t;

  // One word of per-channel history memory.
  typedef struct packed {
    sample_t in1;
    sample_t in2;
    y_t      out1;
    y_t      out2;
  } hist_t;

  // What an item carries down the pipeline next to the arithmetic.
  typedef struct packed {
    sample_t                x;
    logic [CHANNEL_W-1:0]   ch;
    logic                   in_range;
    logic                   prime;
    sample_t                x1;
    y_t                     y1;
  } tag_t;

  // Load strobes of the two multiplier stages.
  typedef struct packed {
    logic load_pp;
    logic load_prod;
  } mul_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/mbq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbq_ram: generic single-write, single-read memory
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module mbq_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mbq_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbq_mul: two-stage signed coefficient multiplier
// The coefficient is split into halves; both partial products are
// registered and then joined into the exact product.
// ----------------------------------------------------------------------------
module mbq_mul #(
  parameter int COEF_BITS = 32,
  parameter int OP_BITS   = 16
) (
  input  logic                                 clk,
  input  mbq_pkg::mul_ctl_t                    ctl,
  input  logic signed [COEF_BITS-1:0]          coef,
  input  logic signed [OP_BITS-1:0]            op,
  output logic signed [COEF_BITS+OP_BITS-1:0]  prod
);

  localparam int LO_W   = COEF_BITS / 2;
  localparam int HI_W   = COEF_BITS - LO_W;
  localparam int PL_W   = LO_W + 1 + OP_BITS;
  localparam int PH_W   = HI_W + OP_BITS;
  localparam int PROD_W = COEF_BITS + OP_BITS;

  logic signed [LO_W:0]       coef_lo;
  logic signed [HI_W-1:0]     coef_hi;
  logic signed [PL_W-1:0]     pp_lo;
  logic signed [PH_W-1:0]     pp_hi;
  logic signed [PROD_W-1:0]   prod_next;

  // The low half is taken as an unsigned magnitude, the high half keeps the sign.
  assign coef_lo = $signed({1'b0, coef[LO_W-1:0]});
  assign coef_hi = coef[COEF_BITS-1:LO_W];

  always_ff @(posedge clk) begin
    if (ctl.load_pp) begin
      pp_lo <= coef_lo * op;
      pp_hi <= coef_hi * op;
    end
  end

  assign prod_next = ({{LO_W{pp_hi[PH_W-1]}}, pp_hi} <<< LO_W)
                   + {{(PROD_W-PL_W){pp_lo[PL_W-1]}}, pp_lo};

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod <= prod_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/multichannel_biquad_highpass.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_biquad_highpass: per-channel second-order IIR filter
// Direct-form-I biquad over interleaved channels, with Q4.x coefficients,
// clamped Q2.30 output history and a priming pass over the first scan.
// ----------------------------------------------------------------------------
// Usage. Input items (sample, channel, scan_end) enter on in_valid/in_stall,
// results (filtered, out_channel) leave on out_valid/out_stall, one result
// per item and in order. Coefficients are written on cfg_write/cfg_index/
// cfg_data while the block is idle; writes to unused indexes are ignored.
// An item can be taken in every cycle as long as the output is not stalled
// and its channel is not one of the six items still in flight: the
// recurrence closes through the history memory, so a channel cannot follow
// itself while its earlier item is in flight. Round-robin traffic over seven
// or more channels then runs at one item per cycle.
// After reset the history memory is cleared, one channel a cycle, while
// in_stall is held high; coefficient writes are taken during that time.
// Items of the first scan prime the history and pass their sample straight
// through; the item with scan_end set ends priming.
// When the receiver stalls, the result stays in the output register and the
// pipeline behind it keeps filling bubbles before in_stall rises.
// ----------------------------------------------------------------------------
module multichannel_biquad_highpass #(
  parameter int CHANNELS  = 64,
  parameter int COEF_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Coefficient write port
  input  logic                                  cfg_write,
  input  logic [mbq_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [COEF_BITS-1:0]                  cfg_data,
  // Input items
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [mbq_pkg::SAMPLE_W-1:0]   sample,
  input  logic [mbq_pkg::CHANNEL_W-1:0]         channel,
  input  logic                                  scan_end,
  // Result items
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mbq_pkg::SAMPLE_W-1:0]   filtered,
  output logic [mbq_pkg::CHANNEL_W-1:0]         out_channel
);

  localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FRAC_BITS = COEF_BITS - 4;
  localparam int P_IN_W    = COEF_BITS + mbq_pkg::SAMPLE_W;
  localparam int P_FB_W    = COEF_BITS + mbq_pkg::Y_W;
  localparam int ACC_W     = COEF_BITS + mbq_pkg::Y_W + 3;
  localparam int SCL_W     = mbq_pkg::Y_W + mbq_pkg::GAIN_SHIFT;
  localparam int STAGES    = 6;

  // Coefficient registers.
  logic signed [COEF_BITS-1:0] coef_ff0, coef_ff1, coef_ff2, coef_fb1, coef_fb2;

  // Reset clearing pass over the history memory.
  logic              clear_active;
  logic [ADDR_W-1:0] clear_cnt;

  logic first_scan;

  // Pipeline control and side data.
  logic [STAGES:1]       s_v;
  logic [STAGES+1:1]     en;
  mbq_pkg::tag_t         tag [1:STAGES];
  logic                  hazard;
  logic                  accept;
  logic                  in_range_in;

  // History memory.
  mbq_pkg::hist_t    hist;
  mbq_pkg::hist_t    wb_data;
  mbq_pkg::hist_t    ram_wdata;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;

  // Arithmetic.
  mbq_pkg::mul_ctl_t          mul_ctl;
  logic signed [P_IN_W-1:0]   p_ff0, p_ff1, p_ff2;
  logic signed [P_FB_W-1:0]   p_fb1, p_fb2;
  logic signed [ACC_W-1:0]    ff_sum, fb_sum, ff_sum_next, fb_sum_next;
  logic signed [ACC_W-1:0]    acc, acc_sh;
  mbq_pkg::y_t                y, y_next;
  logic signed [SCL_W-1:0]    scl, scl_bias, scl_q;
  mbq_pkg::sample_t           filtered_next;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ff0 <= '0;
      coef_ff1 <= '0;
      coef_ff2 <= '0;
      coef_fb1 <= '0;
      coef_fb2 <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        mbq_pkg::REG_FF0: coef_ff0 <= cfg_data;
        mbq_pkg::REG_FF1: coef_ff1 <= cfg_data;
        mbq_pkg::REG_FF2: coef_ff2 <= cfg_data;
        mbq_pkg::REG_FB1: coef_fb1 <= cfg_data;
        mbq_pkg::REG_FB2: coef_fb2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Clearing pass and first-scan flag
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_active <= 1'b1;
      clear_cnt    <= '0;
    end else if (clear_active) begin
      if (clear_cnt == ADDR_W'(CHANNELS - 1)) begin
        clear_active <= 1'b0;
      end else begin
        clear_cnt <= clear_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_scan <= 1'b1;
    end else if (accept && scan_end) begin
      first_scan <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and stage enables
  // --------------------------------------------------------------------------
  // A stage loads when it is empty or when its item moves on.
  always_comb begin
    en[STAGES+1] = !out_valid || !out_stall;
    for (int k = STAGES; k >= 1; k--) begin
      en[k] = !s_v[k] || en[k+1];
    end
  end

  // An item whose channel is still in flight would read stale history.
  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= STAGES; k++) begin
      if (s_v[k] && (tag[k].ch == channel)) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_range_in = (32'(channel) < 32'(CHANNELS));
  assign in_stall    = clear_active || !en[1] || hazard;
  assign accept      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= '0;
    end else begin
      if (en[1]) begin
        s_v[1] <= accept;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) begin
          s_v[k] <= s_v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      tag[1].x        <= sample;
      tag[1].ch       <= channel;
      tag[1].in_range <= in_range_in;
      tag[1].prime    <= first_scan;
      tag[1].x1       <= '0;
      tag[1].y1       <= '0;
    end
    if (en[2]) begin
      tag[2].x        <= tag[1].x;
      tag[2].ch       <= tag[1].ch;
      tag[2].in_range <= tag[1].in_range;
      tag[2].prime    <= tag[1].prime;
      tag[2].x1       <= hist.in1;
      tag[2].y1       <= hist.out1;
    end
    for (int k = 3; k <= STAGES; k++) begin
      if (en[k]) begin
        tag[k] <= tag[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // History memory: read when an item enters, written when it leaves
  // --------------------------------------------------------------------------
  always_comb begin
    if (tag[STAGES].prime) begin
      wb_data.in1  = tag[STAGES].x;
      wb_data.in2  = tag[STAGES].x;
      wb_data.out1 = mbq_pkg::Y_W'(tag[STAGES].x) <<< mbq_pkg::GAIN_SHIFT;
      wb_data.out2 = mbq_pkg::Y_W'(tag[STAGES].x) <<< mbq_pkg::GAIN_SHIFT;
    end else begin
      wb_data.in1  = tag[STAGES].x;
      wb_data.in2  = tag[STAGES].x1;
      wb_data.out1 = y;
      wb_data.out2 = tag[STAGES].y1;
    end
  end

  assign ram_we    = clear_active || (en[STAGES+1] && s_v[STAGES] && tag[STAGES].in_range);
  assign ram_waddr = clear_active ? clear_cnt : ADDR_W'(tag[STAGES].ch);
  assign ram_wdata = clear_active ? '0 : wb_data;

  mbq_ram #(
    .WIDTH ($bits(mbq_pkg::hist_t)),
    .DEPTH (CHANNELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en[1]),
    .raddr (ADDR_W'(channel)),
    .rdata (hist)
  );

  // --------------------------------------------------------------------------
  // Products: operands from stage 1, partial products in stage 2, products
  // in stage 3.
  // --------------------------------------------------------------------------
  assign mul_ctl.load_pp   = en[2];
  assign mul_ctl.load_prod = en[3];

  mbq_mul #(.COEF_BITS(COEF_BITS), .OP_BITS(mbq_pkg::SAMPLE_W)) u_mul_ff0 (
    .clk (clk), .ctl (mul_ctl), .coef (coef_ff0), .op (tag[1].x), .prod (p_ff0)
  );

  mbq_mul #(.COEF_BITS(COEF_BITS), .OP_BITS(mbq_pkg::SAMPLE_W)) u_mul_ff1 (
    .clk (clk), .ctl (mul_ctl), .coef (coef_ff1), .op (hist.in1), .prod (p_ff1)
  );

  mbq_mul #(.COEF_BITS(COEF_BITS), .OP_BITS(mbq_pkg::SAMPLE_W)) u_mul_ff2 (
    .clk (clk), .ctl (mul_ctl), .coef (coef_ff2), .op (hist.in2), .prod (p_ff2)
  );

  mbq_mul #(.COEF_BITS(COEF_BITS), .OP_BITS(mbq_pkg::Y_W)) u_mul_fb1 (
    .clk (clk), .ctl (mul_ctl), .coef (coef_fb1), .op (hist.out1), .prod (p_fb1)
  );

  mbq_mul #(.COEF_BITS(COEF_BITS), .OP_BITS(mbq_pkg::Y_W)) u_mul_fb2 (
    .clk (clk), .ctl (mul_ctl), .coef (coef_fb2), .op (hist.out2), .prod (p_fb2)
  );

  // --------------------------------------------------------------------------
  // Sums (stage 4), difference (stage 5), scale and clamp (stage 6)
  // --------------------------------------------------------------------------
  // Feed-forward products are on raw samples, so they move up to Q.30 here.
  assign ff_sum_next = (ACC_W'(p_ff0) + ACC_W'(p_ff1) + ACC_W'(p_ff2))
                       <<< mbq_pkg::GAIN_SHIFT;
  assign fb_sum_next = ACC_W'(p_fb1) + ACC_W'(p_fb2);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ff_sum <= ff_sum_next;
      fb_sum <= fb_sum_next;
    end
    if (en[5]) begin
      acc <= ff_sum - fb_sum;
    end
    if (en[6]) begin
      y <= y_next;
    end
  end

  // Floor shift back to Q.30, then clamp to plus or minus one.
  assign acc_sh = acc >>> FRAC_BITS;

  always_comb begin
    if (acc_sh > ACC_W'(mbq_pkg::ONE_Q30)) begin
      y_next = mbq_pkg::Y_W'(mbq_pkg::ONE_Q30);
    end else if (acc_sh < ACC_W'(-mbq_pkg::ONE_Q30)) begin
      y_next = mbq_pkg::Y_W'(-mbq_pkg::ONE_Q30);
    end else begin
      y_next = acc_sh[mbq_pkg::Y_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Output: y * 32767 / 2^30, truncated toward zero
  // --------------------------------------------------------------------------
  assign scl      = (SCL_W'(y) <<< mbq_pkg::GAIN_SHIFT) - SCL_W'(y);
  assign scl_bias = scl[SCL_W-1] ? SCL_W'(mbq_pkg::ONE_Q30 - 1) : '0;
  assign scl_q    = (scl + scl_bias) >>> mbq_pkg::Q30_SHIFT;

  always_comb begin
    if (!tag[STAGES].in_range) begin
      filtered_next = '0;
    end else if (tag[STAGES].prime) begin
      filtered_next = tag[STAGES].x;
    end else begin
      filtered_next = scl_q[mbq_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en[STAGES+1]) begin
      out_valid <= s_v[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en[STAGES+1]) begin
      filtered    <= filtered_next;
      out_channel <= tag[STAGES].ch;
    end
  end

`ifndef SYNTHESIS
  // The clearing pass owns the memory write port: nothing may be in flight.
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clear_active |-> (s_v == '0))
    else $error("item in flight during history clearing pass");

  // Two items of one channel never sit in the read stage and at the input.
  a_no_raw: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && s_v[1]) |-> (channel != tag[1].ch))
    else $error("same channel accepted behind an unfinished item");

  // A filtered output history word stays within plus or minus one.
  a_y_range: assert property (@(posedge clk) disable iff (rst)
    (s_v[STAGES] && !tag[STAGES].prime) |->
      ((y <= 32'sd1073741824) && (y >= -32'sd1073741824)))
    else $error("clamped output out of range");

  // Channels beyond the configured count give a zero result.
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (32'(out_channel) >= 32'(CHANNELS))) |-> (filtered == '0))
    else $error("nonzero result for unused channel");
`endif

endmodule
`default_nettype wire
